// ===== hw/rtl/thick_bezier_flattener_unit_assert.svh =====
// assertion macros for the thick bezier flattener unit
`ifndef THICK_BEZIER_FLATTENER_UNIT_ASSERT_SVH
`define THICK_BEZIER_FLATTENER_UNIT_ASSERT_SVH

// same-cycle implication
`define TBF_ASSERT_IMPLY(lbl, ck, rs, a, b, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (b)) else $error(msg);

// next-cycle implication
`define TBF_ASSERT_NEXT(lbl, ck, rs, a, b, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (b)) else $error(msg);

`endif

// ===== hw/rtl/tbf_pkg.sv =====
// shared types, constants and helpers of the thick bezier flattener
package tbf_pkg;

  localparam int COORD_BITS   = 24;
  localparam int MAX_SEGMENTS = 64;
  localparam int SEG_W        = 7;
  localparam int THICK_W      = 16;
  localparam int COLOR_W      = 32;
  localparam int MAG_W        = 24;

  // square root and divider pipelines
  localparam int SQ_IN_W      = 62;
  localparam int ROOT_W       = 31;
  localparam int SQRT_STAGES  = 31;
  localparam int NUM_W        = 48;
  localparam int QUO_W        = 17;
  localparam int DIV_STAGES   = 17;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t               start_x;
    coord_t               start_y;
    coord_t               ctrl_a_x;
    coord_t               ctrl_a_y;
    coord_t               ctrl_b_x;
    coord_t               ctrl_b_y;
    coord_t               end_x;
    coord_t               end_y;
    logic                 is_cubic;
    logic [THICK_W-1:0]   thickness;
    logic [SEG_W-1:0]     segments;
    logic [COLOR_W-1:0]   color;
  } curve_t;

  typedef struct packed {
    coord_t               v0_x;
    coord_t               v0_y;
    coord_t               v1_x;
    coord_t               v1_y;
    coord_t               v2_x;
    coord_t               v2_y;
    coord_t               v3_x;
    coord_t               v3_y;
    logic [COLOR_W-1:0]   quad_color;
    logic                 last;
  } quad_t;

  localparam logic signed [63:0] CMAX = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] CMIN = -CMAX - 64'sd1;

  // clamp a wide signed value to the coordinate range
  function automatic coord_t sat_coord(input logic signed [63:0] v);
    coord_t r;
    if (v > CMAX) r = coord_t'(CMAX);
    else if (v < CMIN) r = coord_t'(CMIN);
    else r = coord_t'(v);
    return r;
  endfunction

endpackage

// ===== hw/rtl/tbf_sqrt_pipe.sv =====
// pipelined integer square root, one result bit per stage
module tbf_sqrt_pipe (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [tbf_pkg::SQ_IN_W-1:0]  radicand,
  output logic                         out_valid,
  output logic [tbf_pkg::ROOT_W-1:0]   root
);
  import tbf_pkg::*;

  logic [SQ_IN_W-1:0] rem_q [SQRT_STAGES];
  logic [SQ_IN_W-1:0] res_q [SQRT_STAGES];
  logic               vld_q [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam logic [SQ_IN_W-1:0] BIT = SQ_IN_W'(1) << (2 * (SQRT_STAGES - 1 - k));
    logic [SQ_IN_W-1:0] x_in, r_in, trial, x_next, r_next;
    logic               v_in;

    if (k == 0) begin : g_head
      assign x_in = radicand;
      assign r_in = '0;
      assign v_in = in_valid;
    end else begin : g_body
      assign x_in = rem_q[k-1];
      assign r_in = res_q[k-1];
      assign v_in = vld_q[k-1];
    end

    // one digit of the root
    always_comb begin
      trial = r_in + BIT;
      if (x_in >= trial) begin
        x_next = x_in - trial;
        r_next = (r_in >> 1) + BIT;
      end else begin
        x_next = x_in;
        r_next = r_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_q[k] <= x_next;
      res_q[k] <= r_next;
    end
  end

  assign out_valid = vld_q[SQRT_STAGES-1];
  assign root      = res_q[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

// ===== hw/rtl/tbf_div_pipe.sv =====
// pipelined restoring divider, two numerators over one shared divisor
module tbf_div_pipe (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [tbf_pkg::NUM_W-1:0]   num_x,
  input  logic [tbf_pkg::NUM_W-1:0]   num_y,
  input  logic [tbf_pkg::ROOT_W-1:0]  den,
  output logic                        out_valid,
  output logic [tbf_pkg::QUO_W-1:0]   quo_x,
  output logic [tbf_pkg::QUO_W-1:0]   quo_y
);
  import tbf_pkg::*;

  logic [NUM_W-1:0]  rx_q [DIV_STAGES];
  logic [NUM_W-1:0]  ry_q [DIV_STAGES];
  logic [QUO_W-1:0]  qx_q [DIV_STAGES];
  logic [QUO_W-1:0]  qy_q [DIV_STAGES];
  logic [ROOT_W-1:0] dd_q [DIV_STAGES];
  logic              vld_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    localparam int SH = QUO_W - 1 - k;
    logic [NUM_W-1:0]  rx_in, ry_in, dsh, rx_next, ry_next;
    logic [QUO_W-1:0]  qx_in, qy_in, qx_next, qy_next;
    logic [ROOT_W-1:0] d_in;
    logic              v_in;

    if (k == 0) begin : g_head
      assign rx_in = num_x;
      assign ry_in = num_y;
      assign qx_in = '0;
      assign qy_in = '0;
      assign d_in  = den;
      assign v_in  = in_valid;
    end else begin : g_body
      assign rx_in = rx_q[k-1];
      assign ry_in = ry_q[k-1];
      assign qx_in = qx_q[k-1];
      assign qy_in = qy_q[k-1];
      assign d_in  = dd_q[k-1];
      assign v_in  = vld_q[k-1];
    end

    // one quotient bit for each numerator
    always_comb begin
      dsh = NUM_W'(d_in) << SH;
      if (rx_in >= dsh) begin
        rx_next = rx_in - dsh;
        qx_next = {qx_in[QUO_W-2:0], 1'b1};
      end else begin
        rx_next = rx_in;
        qx_next = {qx_in[QUO_W-2:0], 1'b0};
      end
      if (ry_in >= dsh) begin
        ry_next = ry_in - dsh;
        qy_next = {qy_in[QUO_W-2:0], 1'b1};
      end else begin
        ry_next = ry_in;
        qy_next = {qy_in[QUO_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rx_q[k] <= rx_next;
      ry_q[k] <= ry_next;
      qx_q[k] <= qx_next;
      qy_q[k] <= qy_next;
      dd_q[k] <= d_in;
    end
  end

  // a zero divisor means a zero-length segment: no offset
  assign out_valid = vld_q[DIV_STAGES-1];
  assign quo_x = (dd_q[DIV_STAGES-1] == '0) ? '0 : qx_q[DIV_STAGES-1];
  assign quo_y = (dd_q[DIV_STAGES-1] == '0) ? '0 : qy_q[DIV_STAGES-1];

endmodule

// ===== hw/rtl/thick_bezier_flattener_unit.sv =====
// top level of the thick bezier flattener: sequencer and segment pipeline
//
// Usage:
//   A curve transfer happens on a rising edge with start high and busy low.
//   The block then emits one quad per segment on quad, each marked by
//   quad_valid for exactly one cycle; quad.last flags the final segment.
//   The receiver cannot hold quads off, and the block never needs it to.
// Timing:
//   After a transfer the sequencer runs a serial divide of 1.0 by the
//   segment count, then issues one segment per cycle until the last one,
//   and busy stays high until then. The segment pipeline (weights, point
//   sum, length, square root of 31 stages, offset divider of 17 stages,
//   corners) takes one segment per cycle, and the quads of a curve follow
//   back to back.
// Reset:
//   rst clears the sequencer and every pipeline valid; no quad is emitted
//   until a new curve is taken.
`include "thick_bezier_flattener_unit_assert.svh"

module thick_bezier_flattener_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  tbf_pkg::curve_t curve,
  output logic            quad_valid,
  output tbf_pkg::quad_t  quad
);
  import tbf_pkg::*;

  localparam int CW       = COORD_BITS;
  localparam int PW       = CW + 33;
  localparam int SW       = PW + 2;
  localparam int HALF_MAX = CW - MAG_W;
  localparam int SIDE_LEN = SQRT_STAGES + DIV_STAGES + 2;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;

  localparam logic [16:0] T_ONE = 17'h10000;

  typedef struct packed {
    coord_t             px;
    coord_t             py;
    coord_t             nx;
    coord_t             ny;
    logic [COLOR_W-1:0] color;
    logic               last;
    logic               neg_ox;
    logic               neg_oy;
    logic [MAG_W-1:0]   mag_x;
    logic [MAG_W-1:0]   mag_y;
    logic [THICK_W-1:0] thick;
  } side_t;

  // ---------------- sequencer ----------------
  logic [1:0]       state;
  curve_t           cur;
  logic [SEG_W-1:0] seg_n, seg_i;
  logic [4:0]       div_cnt;
  logic [SEG_W-1:0] div_rem;
  logic [16:0]      div_quo;
  logic [16:0]      acc_q;
  logic [SEG_W-1:0] acc_r;
  logic [SEG_W-1:0] n_clamped;
  logic [SEG_W:0]   trial;
  logic [SEG_W:0]   sum_r;
  logic [16:0]      sum_q;
  logic [SEG_W-1:0] r_next;
  logic [16:0]      q_next;

  assign busy = (state != S_IDLE);

  // segment count repair
  always_comb begin
    if (curve.segments == '0) n_clamped = SEG_W'(1);
    else if (curve.segments > SEG_W'(MAX_SEGMENTS)) n_clamped = SEG_W'(MAX_SEGMENTS);
    else n_clamped = curve.segments;
  end

  // serial divide step and running t = i / n with remainder
  always_comb begin
    trial = {div_rem, (div_cnt == 5'd0)};
    sum_r = {1'b0, acc_r} + {1'b0, div_rem};
    sum_q = acc_q + div_quo;
    if (sum_r >= {1'b0, seg_n}) begin
      r_next = SEG_W'(sum_r - {1'b0, seg_n});
      q_next = sum_q + 17'd1;
    end else begin
      r_next = sum_r[SEG_W-1:0];
      q_next = sum_q;
    end
  end

  logic        iss_valid, iss_last, iss_first;
  logic [16:0] iss_t;
  curve_t      iss_curve;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      iss_valid <= 1'b0;
    end else begin
      iss_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) state <= S_DIV;
        end
        S_DIV: begin
          if (div_cnt == 5'd16) state <= S_RUN;
        end
        S_RUN: begin
          iss_valid <= 1'b1;
          if (seg_i == seg_n) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur     <= curve;
        seg_n   <= n_clamped;
        div_cnt <= '0;
        div_rem <= '0;
        div_quo <= '0;
      end
      S_DIV: begin
        if (trial >= {1'b0, seg_n}) begin
          div_rem <= SEG_W'(trial - {1'b0, seg_n});
          div_quo <= {div_quo[15:0], 1'b1};
        end else begin
          div_rem <= trial[SEG_W-1:0];
          div_quo <= {div_quo[15:0], 1'b0};
        end
        div_cnt <= div_cnt + 5'd1;
        acc_q   <= '0;
        acc_r   <= seg_n >> 1;
        seg_i   <= SEG_W'(1);
      end
      S_RUN: begin
        acc_q     <= q_next;
        acc_r     <= r_next;
        seg_i     <= seg_i + SEG_W'(1);
        iss_t     <= (seg_i == seg_n) ? T_ONE : q_next;
        iss_last  <= (seg_i == seg_n);
        iss_first <= (seg_i == SEG_W'(1));
        iss_curve <= cur;
      end
      default: ;
    endcase
  end

  // ---------------- weight stage a: squares ----------------
  logic        a_valid, a_last, a_first;
  curve_t      a_curve;
  logic [16:0] a_u, a_t;
  logic [33:0] a_uu, a_tt, a_ut;

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else a_valid <= iss_valid;
  end

  always_ff @(posedge clk) begin
    a_u     <= T_ONE - iss_t;
    a_t     <= iss_t;
    a_uu    <= (T_ONE - iss_t) * (T_ONE - iss_t);
    a_tt    <= iss_t * iss_t;
    a_ut    <= (T_ONE - iss_t) * iss_t;
    a_last  <= iss_last;
    a_first <= iss_first;
    a_curve <= iss_curve;
  end

  // ---------------- weight stage b: cubes, quadratic weights ----------------
  logic        b_valid, b_last, b_first;
  curve_t      b_curve;
  logic [50:0] b_uuu, b_uut, b_utt, b_ttt;
  logic [31:0] b_q0, b_q1, b_q2;

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else b_valid <= a_valid;
  end

  always_ff @(posedge clk) begin
    b_uuu   <= a_uu * a_u;
    b_uut   <= a_uu * a_t;
    b_utt   <= a_tt * a_u;
    b_ttt   <= a_tt * a_t;
    b_q0    <= 32'((36'(a_uu) + 36'd2) >> 2);
    b_q1    <= 32'((36'({a_ut, 1'b0}) + 36'd2) >> 2);
    b_q2    <= 32'((36'(a_tt) + 36'd2) >> 2);
    b_last  <= a_last;
    b_first <= a_first;
    b_curve <= a_curve;
  end

  // ---------------- weight stage c: cubic rounding and selection ----------------
  logic        c_valid, c_last, c_first;
  curve_t      c_curve;
  logic [31:0] c_w [4];
  logic [52:0] cub_w [4];

  always_comb begin
    cub_w[0] = (53'(b_uuu) + 53'h20000) >> 18;
    cub_w[1] = (53'({b_uut, 1'b0}) + 53'(b_uut) + 53'h20000) >> 18;
    cub_w[2] = (53'({b_utt, 1'b0}) + 53'(b_utt) + 53'h20000) >> 18;
    cub_w[3] = (53'(b_ttt) + 53'h20000) >> 18;
  end

  always_ff @(posedge clk) begin
    if (rst) c_valid <= 1'b0;
    else c_valid <= b_valid;
  end

  // quadratic weights land on start, first control and end
  always_ff @(posedge clk) begin
    if (b_curve.is_cubic) begin
      c_w[0] <= cub_w[0][31:0];
      c_w[1] <= cub_w[1][31:0];
      c_w[2] <= cub_w[2][31:0];
      c_w[3] <= cub_w[3][31:0];
    end else begin
      c_w[0] <= b_q0;
      c_w[1] <= b_q1;
      c_w[2] <= '0;
      c_w[3] <= b_q2;
    end
    c_last  <= b_last;
    c_first <= b_first;
    c_curve <= b_curve;
  end

  // ---------------- product stage ----------------
  logic                 m_valid, m_last, m_first;
  curve_t               m_curve;
  logic signed [PW-1:0] m_px [4];
  logic signed [PW-1:0] m_py [4];
  coord_t               cx [4];
  coord_t               cy [4];

  assign cx[0] = c_curve.start_x;
  assign cx[1] = c_curve.ctrl_a_x;
  assign cx[2] = c_curve.ctrl_b_x;
  assign cx[3] = c_curve.end_x;
  assign cy[0] = c_curve.start_y;
  assign cy[1] = c_curve.ctrl_a_y;
  assign cy[2] = c_curve.ctrl_b_y;
  assign cy[3] = c_curve.end_y;

  always_ff @(posedge clk) begin
    if (rst) m_valid <= 1'b0;
    else m_valid <= c_valid;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      m_px[k] <= $signed({1'b0, c_w[k]}) * cx[k];
      m_py[k] <= $signed({1'b0, c_w[k]}) * cy[k];
    end
    m_last  <= c_last;
    m_first <= c_first;
    m_curve <= c_curve;
  end

  // ---------------- point stage: sum, round, saturate ----------------
  logic                 s_valid, s_last, s_first;
  curve_t               s_curve;
  coord_t               s_nx, s_ny;
  logic signed [SW-1:0] sum_x, sum_y;

  always_comb begin
    sum_x = SW'(m_px[0]) + SW'(m_px[1]) + SW'(m_px[2]) + SW'(m_px[3])
            + (SW'(1) <<< 29);
    sum_y = SW'(m_py[0]) + SW'(m_py[1]) + SW'(m_py[2]) + SW'(m_py[3])
            + (SW'(1) <<< 29);
  end

  always_ff @(posedge clk) begin
    if (rst) s_valid <= 1'b0;
    else s_valid <= m_valid;
  end

  always_ff @(posedge clk) begin
    s_nx    <= sat_coord(64'(sum_x >>> 30));
    s_ny    <= sat_coord(64'(sum_y >>> 30));
    s_last  <= m_last;
    s_first <= m_first;
    s_curve <= m_curve;
  end

  // ---------------- direction stage ----------------
  coord_t             prev_x, prev_y;
  coord_t             seg_px, seg_py;
  logic signed [CW:0] dx, dy;
  logic [CW-1:0]      abs_x, abs_y;
  logic [5:0]         hsh;
  logic               d_valid;
  side_t              d_side;

  always_comb begin
    seg_px = s_first ? s_curve.start_x : prev_x;
    seg_py = s_first ? s_curve.start_y : prev_y;
    dx = (CW+1)'(s_nx) - (CW+1)'(seg_px);
    dy = (CW+1)'(s_ny) - (CW+1)'(seg_py);
    abs_x = dx[CW] ? CW'(-dx) : dx[CW-1:0];
    abs_y = dy[CW] ? CW'(-dy) : dy[CW-1:0];
    // halve both magnitudes until they fit the length datapath
    hsh = '0;
    for (int k = HALF_MAX; k >= 0; k--) begin
      if ((((abs_x | abs_y) >> k) >> MAG_W) == '0) hsh = 6'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) d_valid <= 1'b0;
    else d_valid <= s_valid;
  end

  always_ff @(posedge clk) begin
    if (s_valid) begin
      prev_x <= s_nx;
      prev_y <= s_ny;
    end
    d_side.px     <= seg_px;
    d_side.py     <= seg_py;
    d_side.nx     <= s_nx;
    d_side.ny     <= s_ny;
    d_side.color  <= s_curve.color;
    d_side.last   <= s_last;
    d_side.neg_ox <= !dy[CW] && (dy != '0);
    d_side.neg_oy <= dx[CW];
    d_side.mag_x  <= MAG_W'(abs_x >> hsh);
    d_side.mag_y  <= MAG_W'(abs_y >> hsh);
    d_side.thick  <= s_curve.thickness;
  end

  // ---------------- squared length stage ----------------
  logic              q_valid;
  logic [2*MAG_W:0]  q_len2;

  always_ff @(posedge clk) begin
    if (rst) q_valid <= 1'b0;
    else q_valid <= d_valid;
  end

  always_ff @(posedge clk) begin
    q_len2 <= (2*MAG_W+1)'(d_side.mag_x * d_side.mag_x)
              + (2*MAG_W+1)'(d_side.mag_y * d_side.mag_y);
  end

  // side data rides along the root and divider pipelines
  side_t sd [SIDE_LEN];

  always_ff @(posedge clk) begin
    sd[0] <= d_side;
    for (int k = 1; k < SIDE_LEN; k++) sd[k] <= sd[k-1];
  end

  // ---------------- square root ----------------
  logic              r_valid;
  logic [ROOT_W-1:0] r_root;

  tbf_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .radicand  (SQ_IN_W'({q_len2, 12'b0})),
    .out_valid (r_valid),
    .root      (r_root)
  );

  // ---------------- numerator stage ----------------
  logic              n_valid;
  logic [NUM_W-1:0]  n_num_x, n_num_y;
  logic [ROOT_W-1:0] n_den;
  logic [MAG_W+THICK_W-1:0] prod_x, prod_y;

  assign prod_x = sd[SQRT_STAGES].mag_y * sd[SQRT_STAGES].thick;
  assign prod_y = sd[SQRT_STAGES].mag_x * sd[SQRT_STAGES].thick;

  always_ff @(posedge clk) begin
    if (rst) n_valid <= 1'b0;
    else n_valid <= r_valid;
  end

  always_ff @(posedge clk) begin
    n_num_x <= (NUM_W'(prod_x) << 5) + NUM_W'(r_root >> 1);
    n_num_y <= (NUM_W'(prod_y) << 5) + NUM_W'(r_root >> 1);
    n_den   <= r_root;
  end

  // ---------------- offset divide ----------------
  logic             o_valid;
  logic [QUO_W-1:0] o_qx, o_qy;

  tbf_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (n_valid),
    .num_x     (n_num_x),
    .num_y     (n_num_y),
    .den       (n_den),
    .out_valid (o_valid),
    .quo_x     (o_qx),
    .quo_y     (o_qy)
  );

  // ---------------- corner stage ----------------
  side_t                  fs;
  logic signed [QUO_W:0]  ox, oy;

  assign fs = sd[SIDE_LEN-1];
  assign ox = fs.neg_ox ? -$signed({1'b0, o_qx}) : $signed({1'b0, o_qx});
  assign oy = fs.neg_oy ? -$signed({1'b0, o_qy}) : $signed({1'b0, o_qy});

  always_ff @(posedge clk) begin
    if (rst) quad_valid <= 1'b0;
    else quad_valid <= o_valid;
  end

  always_ff @(posedge clk) begin
    quad.v0_x       <= sat_coord(64'(fs.px) + 64'(ox));
    quad.v0_y       <= sat_coord(64'(fs.py) + 64'(oy));
    quad.v1_x       <= sat_coord(64'(fs.px) - 64'(ox));
    quad.v1_y       <= sat_coord(64'(fs.py) - 64'(oy));
    quad.v2_x       <= sat_coord(64'(fs.nx) - 64'(ox));
    quad.v2_y       <= sat_coord(64'(fs.ny) - 64'(oy));
    quad.v3_x       <= sat_coord(64'(fs.nx) + 64'(ox));
    quad.v3_y       <= sat_coord(64'(fs.ny) + 64'(oy));
    quad.quad_color <= fs.color;
    quad.last       <= fs.last;
  end

  // ---------------- checks ----------------
  `TBF_ASSERT_NEXT(a_take_busy, clk, rst, start && !busy, busy, "curve taken but not busy")
  `TBF_ASSERT_NEXT(a_run_end, clk, rst, (state == S_RUN) && (seg_i == seg_n), !busy, "sequencer ran past the last segment")
  `TBF_ASSERT_NEXT(a_quads_contig, clk, rst, quad_valid && !quad.last, quad_valid, "gap inside a curve's quads")

endmodule

// ===== bench/quad_checker.sv =====
// checker for the thick bezier flattener: predicts quads from curve transfers and compares
module quad_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            busy,
  input  tbf_pkg::curve_t curve,
  input  logic            quad_valid,
  input  tbf_pkg::quad_t  quad,
  output int              errors,
  output int              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tbf_pkg::*;

  quad_t expected_quads[$];

  // clamp to the signed coordinate range
  function automatic longint clamp_coord(longint v);
    longint hi;
    hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // integer square root, floor
  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // signed half-thickness offset component, rounded half away from zero
  function automatic longint offset_part(bit neg, longint unsigned mag,
                                         longint unsigned th, longint unsigned len);
    longint unsigned q;
    if (len == 0) return 0;
    q = (mag * th * 32 + len / 2) / len;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // flatten one curve into its quads
  task automatic flatten_curve(curve_t c);
    longint p[8];
    longint px, py, nx, ny, dx, dy, ox, oy;
    longint unsigned n, t, u, ax, ay, len, th;
    longint unsigned w[4];
    quad_t q;
    p[0] = longint'(c.start_x);  p[1] = longint'(c.start_y);
    p[2] = longint'(c.ctrl_a_x); p[3] = longint'(c.ctrl_a_y);
    p[4] = longint'(c.ctrl_b_x); p[5] = longint'(c.ctrl_b_y);
    p[6] = longint'(c.end_x);    p[7] = longint'(c.end_y);
    th = c.thickness;
    n = c.segments;
    if (n == 0) n = 1;
    if (n > MAX_SEGMENTS) n = MAX_SEGMENTS;
    px = p[0];
    py = p[1];
    for (longint unsigned i = 1; i <= n; i++) begin
      t = (i == n) ? 65536 : (i * 65536 + n / 2) / n;
      u = 65536 - t;
      if (c.is_cubic) begin
        w[0] = (u * u * u + (1 << 17)) >> 18;
        w[1] = (3 * u * u * t + (1 << 17)) >> 18;
        w[2] = (3 * u * t * t + (1 << 17)) >> 18;
        w[3] = (t * t * t + (1 << 17)) >> 18;
        nx = longint'(w[0]) * p[0] + longint'(w[1]) * p[2]
           + longint'(w[2]) * p[4] + longint'(w[3]) * p[6];
        ny = longint'(w[0]) * p[1] + longint'(w[1]) * p[3]
           + longint'(w[2]) * p[5] + longint'(w[3]) * p[7];
      end else begin
        w[0] = (u * u + 2) >> 2;
        w[1] = (2 * u * t + 2) >> 2;
        w[2] = (t * t + 2) >> 2;
        nx = longint'(w[0]) * p[0] + longint'(w[1]) * p[2] + longint'(w[2]) * p[6];
        ny = longint'(w[0]) * p[1] + longint'(w[1]) * p[3] + longint'(w[2]) * p[7];
      end
      nx = clamp_coord((nx + (longint'(1) <<< 29)) >>> 30);
      ny = clamp_coord((ny + (longint'(1) <<< 29)) >>> 30);
      dx = nx - px;
      dy = ny - py;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      while (ax >= (64'd1 << 24) || ay >= (64'd1 << 24)) begin
        ax >>= 1;
        ay >>= 1;
      end
      len = floor_root((ax * ax + ay * ay) << 12);
      ox = offset_part(dy > 0, ay, th, len);
      oy = offset_part(dx < 0, ax, th, len);
      q.v0_x = coord_t'(clamp_coord(px + ox));
      q.v0_y = coord_t'(clamp_coord(py + oy));
      q.v1_x = coord_t'(clamp_coord(px - ox));
      q.v1_y = coord_t'(clamp_coord(py - oy));
      q.v2_x = coord_t'(clamp_coord(nx - ox));
      q.v2_y = coord_t'(clamp_coord(ny - oy));
      q.v3_x = coord_t'(clamp_coord(nx + ox));
      q.v3_y = coord_t'(clamp_coord(ny + oy));
      q.quad_color = c.color;
      q.last = (i == n);
      expected_quads.push_back(q);
      px = nx;
      py = ny;
    end
  endtask

  // compare one field
  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  // watch curve transfers and quad outputs
  always @(posedge clk) begin
    quad_t e;
    if (!rst) begin
      if (start && !busy) flatten_curve(curve);
      if (quad_valid) begin
        if (expected_quads.size() == 0) begin
          $error("quad transfer with no quad expected");
          errors++;
        end else begin
          e = expected_quads.pop_front();
          check_field("v0_x", e.v0_x, quad.v0_x);
          check_field("v0_y", e.v0_y, quad.v0_y);
          check_field("v1_x", e.v1_x, quad.v1_x);
          check_field("v1_y", e.v1_y, quad.v1_y);
          check_field("v2_x", e.v2_x, quad.v2_x);
          check_field("v2_y", e.v2_y, quad.v2_y);
          check_field("v3_x", e.v3_x, quad.v3_x);
          check_field("v3_y", e.v3_y, quad.v3_y);
          check_field("quad_color", e.quad_color, quad.quad_color);
          check_field("last", e.last, quad.last);
        end
      end
    end
    pending = expected_quads.size();
  end
endmodule

// ===== bench/testbench.sv =====
// top of the thick bezier flattener bench: clock, reset, curve stimulus and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tbf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam coord_t C_HI = coord_t'(24'h7FFFFF);
  localparam coord_t C_LO = coord_t'(24'h800000);

  logic   clk;
  logic   rst;
  logic   start;
  logic   busy;
  curve_t curve;
  logic   quad_valid;
  quad_t  quad;
  int     errors;
  int     pending;
  int     cycles;
  bit     no_gaps;

  thick_bezier_flattener_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .curve(curve), .quad_valid(quad_valid), .quad(quad)
  );

  quad_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .curve(curve),
    .quad_valid(quad_valid), .quad(quad), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // run-away guard
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // coordinate: mostly near the origin, sometimes anywhere
  function automatic coord_t rand_coord();
    if ($urandom_range(0, 3) == 0) return coord_t'($urandom());
    return coord_t'($signed($urandom_range(0, 131071)) - 65536);
  endfunction

  function automatic curve_t rand_curve();
    curve_t c;
    c.start_x = rand_coord();  c.start_y = rand_coord();
    c.ctrl_a_x = rand_coord(); c.ctrl_a_y = rand_coord();
    c.ctrl_b_x = rand_coord(); c.ctrl_b_y = rand_coord();
    c.end_x = rand_coord();    c.end_y = rand_coord();
    c.is_cubic = 1'($urandom_range(0, 1));
    c.thickness = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 4095));
    case ($urandom_range(0, 9))
      0: c.segments = 7'($urandom_range(0, 127));
      1, 2: c.segments = 7'($urandom_range(1, 64));
      default: c.segments = 7'($urandom_range(1, 8));
    endcase
    c.color = $urandom();
    return c;
  endfunction

  function automatic curve_t flat_curve(coord_t v, bit cubic, logic [15:0] th,
                                        logic [6:0] n);
    curve_t c;
    c.start_x = v; c.start_y = v; c.ctrl_a_x = v; c.ctrl_a_y = v;
    c.ctrl_b_x = v; c.ctrl_b_y = v; c.end_x = v; c.end_y = v;
    c.is_cubic = cubic; c.thickness = th; c.segments = n;
    c.color = $urandom();
    return c;
  endfunction

  // one curve transfer, after a random gap unless no_gaps is set
  task automatic send_curve(curve_t c);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    curve <= c;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    curve_t c;
    rst = 1'b1;
    start = 1'b0;
    curve = '0;
    no_gaps = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corner cases: extremes, zero length, counts out of range, overshoot
    send_curve(flat_curve(C_HI, 1, 16'hFFFF, 7'd4));
    send_curve(flat_curve(C_LO, 0, 16'hFFFF, 7'd3));
    send_curve(flat_curve(coord_t'(0), 1, 16'd0, 7'd0));
    c = flat_curve(C_LO, 0, 16'hFFFF, 7'd64);
    c.end_x = C_HI; c.ctrl_a_y = C_HI; c.color = 32'hFFFF_FFFF;
    send_curve(c);
    c = flat_curve(C_HI, 1, 16'h0100, 7'd127);
    c.ctrl_a_x = C_LO; c.ctrl_b_y = C_LO; c.end_y = C_LO; c.color = 32'h0;
    send_curve(c);
    c = flat_curve(coord_t'(0), 1, 16'h0200, 7'd65);
    c.end_x = coord_t'(25600); c.ctrl_a_y = coord_t'(-12800);
    send_curve(c);
    c = flat_curve(C_LO, 1, 16'hFFFF, 7'd1);
    c.end_y = C_HI; c.ctrl_b_x = C_HI;
    send_curve(c);
    c = flat_curve(coord_t'(1000), 0, 16'h0080, 7'd2);
    c.end_x = coord_t'(1001);
    send_curve(c);
    for (int k = 0; k < 6; k++) send_curve(rand_curve());

    // hold off until the block has drained
    start <= 1'b0;
    wait (pending == 0);
    repeat (100) @(posedge clk);

    // random curves, with a back-to-back burst in the middle
    for (int k = 0; k < 160; k++) begin
      no_gaps = (k >= 60 && k < 80);
      send_curve(rand_curve());
    end
    start <= 1'b0;

    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== thick_bezier_flattener_unit.f =====
+incdir+hw/rtl
hw/rtl/tbf_pkg.sv
hw/rtl/tbf_sqrt_pipe.sv
hw/rtl/tbf_div_pipe.sv
hw/rtl/thick_bezier_flattener_unit.sv
bench/quad_checker.sv
bench/testbench.sv
